[rtl/nps_pkg.sv]
// Package for the next-prime search block: widths, register codes, microcode
// types and step addresses. Used by every module in rtl/ and by the checker.
package nps_pkg;

    localparam int VALUE_WIDTH     = 16;
    localparam int TDATA_WIDTH     = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int FLOOR_WIDTH     = 16;
    localparam int CEIL_WIDTH      = 15;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = FLOOR_WIDTH;
    // Trial divisors never pass the square root of the largest magnitude.
    localparam int DIV_WIDTH       = VALUE_WIDTH / 2 + 2;
    localparam int SQ_WIDTH        = VALUE_WIDTH + 2;
    localparam int CNT_WIDTH       = $clog2(VALUE_WIDTH);
    localparam int CMP_WIDTH       = (VALUE_WIDTH > FLOOR_WIDTH ? VALUE_WIDTH : FLOOR_WIDTH) + 1;
    localparam int UPC_WIDTH       = 4;

    localparam logic [FLOOR_WIDTH-1:0] FLOOR_RESET = FLOOR_WIDTH'(-32000);
    localparam logic [CEIL_WIDTH-1:0]  CEIL_RESET  = CEIL_WIDTH'(32000);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FLOOR   = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CEILING = CFG_INDEX_WIDTH'(1);

    typedef logic [UPC_WIDTH-1:0] upc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MAG,
        OP_INIT_DIV,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_NEXT_D,
        OP_SET_FOUND,
        OP_MOVE,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_MAG_LT2,
        COND_MAG_LT4,
        COND_MAG_EVEN,
        COND_SQ_GT_MAG,
        COND_BIT_MORE,
        COND_REM_ZERO,
        COND_AT_BOUND,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        upc_t   target;
    } ucode_t;

    typedef struct packed {
        logic no_input;
        logic mag_lt2;
        logic mag_lt4;
        logic mag_even;
        logic sq_gt_mag;
        logic bit_more;
        logic rem_zero;
        logic at_bound;
        logic out_busy;
    } status_t;

    // Step addresses of the control program.
    localparam upc_t UPC_IDLE   = 4'd0;
    localparam upc_t UPC_MAG    = 4'd1;
    localparam upc_t UPC_TINY   = 4'd2;
    localparam upc_t UPC_SMALL  = 4'd3;
    localparam upc_t UPC_EVEN   = 4'd4;
    localparam upc_t UPC_LOOP   = 4'd5;
    localparam upc_t UPC_DIV    = 4'd6;
    localparam upc_t UPC_TEST   = 4'd7;
    localparam upc_t UPC_BACK   = 4'd8;
    localparam upc_t UPC_PRIME  = 4'd9;
    localparam upc_t UPC_STEP   = 4'd10;
    localparam upc_t UPC_RETRY  = 4'd11;
    localparam upc_t UPC_EMIT   = 4'd12;
    localparam upc_t UPC_DONE   = 4'd13;

endpackage

[rtl/nps_ucode_rom.sv]
// Control store of the next-prime search: one control word per step.
// Depends on nps_pkg for the control word layout and step addresses.
module nps_ucode_rom (
    input  nps_pkg::upc_t   addr,
    output nps_pkg::ucode_t cw
);
    import nps_pkg::*;

    always_comb begin
        unique case (addr)
            UPC_IDLE:  cw = '{op: OP_LOAD,      cond: COND_NO_INPUT,  target: UPC_IDLE};
            UPC_MAG:   cw = '{op: OP_MAG,       cond: COND_NEVER,     target: UPC_IDLE};
            UPC_TINY:  cw = '{op: OP_NOP,       cond: COND_MAG_LT2,   target: UPC_STEP};
            // Magnitudes two and three are prime.
            UPC_SMALL: cw = '{op: OP_NOP,       cond: COND_MAG_LT4,   target: UPC_PRIME};
            UPC_EVEN:  cw = '{op: OP_INIT_DIV,  cond: COND_MAG_EVEN,  target: UPC_STEP};
            UPC_LOOP:  cw = '{op: OP_DIV_START, cond: COND_SQ_GT_MAG, target: UPC_PRIME};
            UPC_DIV:   cw = '{op: OP_DIV_STEP,  cond: COND_BIT_MORE,  target: UPC_DIV};
            UPC_TEST:  cw = '{op: OP_NEXT_D,    cond: COND_REM_ZERO,  target: UPC_STEP};
            UPC_BACK:  cw = '{op: OP_NOP,       cond: COND_ALWAYS,    target: UPC_LOOP};
            UPC_PRIME: cw = '{op: OP_SET_FOUND, cond: COND_ALWAYS,    target: UPC_EMIT};
            UPC_STEP:  cw = '{op: OP_MOVE,      cond: COND_AT_BOUND,  target: UPC_EMIT};
            UPC_RETRY: cw = '{op: OP_NOP,       cond: COND_ALWAYS,    target: UPC_MAG};
            UPC_EMIT:  cw = '{op: OP_EMIT,      cond: COND_OUT_BUSY,  target: UPC_EMIT};
            UPC_DONE:  cw = '{op: OP_NOP,       cond: COND_ALWAYS,    target: UPC_IDLE};
            default:   cw = '{op: OP_NOP,       cond: COND_ALWAYS,    target: UPC_IDLE};
        endcase
    end

endmodule

[rtl/nps_sequencer.sv]
// Step counter of the next-prime search with conditional jumps.
// Depends on nps_pkg for the control word and status types.
module nps_sequencer (
    input  logic            aclk,
    input  logic            aresetn,
    input  nps_pkg::ucode_t cw,
    input  nps_pkg::status_t status,
    output nps_pkg::upc_t   upc
);
    import nps_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic taken;

    always_comb begin
        unique case (cw.cond)
            COND_NEVER:     taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_NO_INPUT:  taken = status.no_input;
            COND_MAG_LT2:   taken = status.mag_lt2;
            COND_MAG_LT4:   taken = status.mag_lt4;
            COND_MAG_EVEN:  taken = status.mag_even;
            COND_SQ_GT_MAG: taken = status.sq_gt_mag;
            COND_BIT_MORE:  taken = status.bit_more;
            COND_REM_ZERO:  taken = status.rem_zero;
            COND_AT_BOUND:  taken = status.at_bound;
            COND_OUT_BUSY:  taken = status.out_busy;
            default:        taken = 1'b1;
        endcase
        upc_next = taken ? cw.target : upc_t'(upc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    assign upc = upc_reg;

endmodule

[rtl/nps_datapath.sv]
// Datapath of the next-prime search: candidate, trial divisor, one-bit-per-cycle
// remainder unit, bound registers and the result register. Depends on nps_pkg.
module nps_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  nps_pkg::ucode_t                     cw,
    output nps_pkg::status_t                    status,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [nps_pkg::VALUE_WIDTH-1:0]     start_value,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nps_pkg::VALUE_WIDTH-1:0]     prime_value,
    output logic                                found,
    input  logic                                cfg_valid,
    input  logic [nps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [nps_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import nps_pkg::*;

    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] cand_reg, cand_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [VALUE_WIDTH-1:0] shf_reg, shf_next;
    logic [DIV_WIDTH-1:0]   d_reg, d_next;
    logic [DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [SQ_WIDTH-1:0]    sq_reg, sq_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                   found_reg, found_next;
    logic [FLOOR_WIDTH-1:0] floor_reg, floor_next;
    logic [CEIL_WIDTH-1:0]  ceil_reg, ceil_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic                   out_found_reg, out_found_next;

    logic                   negative;
    logic                   out_busy;
    logic [DIV_WIDTH:0]     trial;
    logic [DIV_WIDTH:0]     trial_diff;
    logic [CMP_WIDTH-1:0]   cand_ext, floor_ext, ceil_ext;

    assign negative  = n_reg[VALUE_WIDTH-1];
    assign out_busy  = out_valid_reg && !m_tready;
    assign cand_ext  = {{(CMP_WIDTH-VALUE_WIDTH){cand_reg[VALUE_WIDTH-1]}}, cand_reg};
    assign floor_ext = {{(CMP_WIDTH-FLOOR_WIDTH){floor_reg[FLOOR_WIDTH-1]}}, floor_reg};
    assign ceil_ext  = {{(CMP_WIDTH-CEIL_WIDTH){1'b0}}, ceil_reg};

    // Restoring remainder step: bring in the next magnitude bit, subtract if it fits.
    assign trial      = {rem_reg, shf_reg[VALUE_WIDTH-1]};
    assign trial_diff = trial - {1'b0, d_reg};

    always_comb begin
        status.no_input  = !s_tvalid;
        status.mag_lt2   = (mag_reg < VALUE_WIDTH'(2));
        status.mag_lt4   = (mag_reg < VALUE_WIDTH'(4));
        status.mag_even  = !mag_reg[0];
        status.sq_gt_mag = (sq_reg > {{(SQ_WIDTH-VALUE_WIDTH){1'b0}}, mag_reg});
        status.bit_more  = (cnt_reg != CNT_WIDTH'(VALUE_WIDTH - 1));
        status.rem_zero  = (rem_reg == '0);
        status.at_bound  = negative ? ($signed(cand_ext) <= $signed(floor_ext))
                                    : ($signed(cand_ext) >= $signed(ceil_ext));
        status.out_busy  = out_busy;
    end

    assign s_tready = (cw.op == OP_LOAD);

    always_comb begin
        n_next         = n_reg;
        cand_next      = cand_reg;
        mag_next       = mag_reg;
        shf_next       = shf_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        sq_next        = sq_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        out_value_next = out_value_reg;
        out_found_next = out_found_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (cw.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                if (s_tvalid) begin
                    n_next     = start_value;
                    cand_next  = start_value;
                    found_next = 1'b0;
                end
            end
            OP_MAG: begin
                mag_next = cand_reg[VALUE_WIDTH-1] ? VALUE_WIDTH'(~cand_reg + 1'b1) : cand_reg;
            end
            OP_INIT_DIV: begin
                d_next  = DIV_WIDTH'(3);
                sq_next = SQ_WIDTH'(9);
            end
            OP_DIV_START: begin
                rem_next = '0;
                shf_next = mag_reg;
                cnt_next = '0;
            end
            OP_DIV_STEP: begin
                rem_next = trial_diff[DIV_WIDTH] ? trial[DIV_WIDTH-1:0]
                                                 : trial_diff[DIV_WIDTH-1:0];
                shf_next = {shf_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = CNT_WIDTH'(cnt_reg + 1'b1);
            end
            OP_NEXT_D: begin
                // Next odd divisor; (d+2)^2 = d^2 + 4d + 4.
                d_next  = DIV_WIDTH'(d_reg + 2'd2);
                sq_next = SQ_WIDTH'(sq_reg + {d_reg, 2'b00} + 3'd4);
            end
            OP_SET_FOUND: begin
                found_next = 1'b1;
            end
            OP_MOVE: begin
                cand_next = negative ? VALUE_WIDTH'(cand_reg - 1'b1)
                                     : VALUE_WIDTH'(cand_reg + 1'b1);
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    out_valid_next = 1'b1;
                    out_value_next = found_reg ? cand_reg : n_reg;
                    out_found_next = found_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        floor_next = floor_reg;
        ceil_next  = ceil_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_FLOOR) begin
                floor_next = cfg_data[FLOOR_WIDTH-1:0];
            end else if (cfg_index == CFG_CEILING) begin
                ceil_next = cfg_data[CEIL_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            floor_reg     <= FLOOR_RESET;
            ceil_reg      <= CEIL_RESET;
        end else begin
            out_valid_reg <= out_valid_next;
            floor_reg     <= floor_next;
            ceil_reg      <= ceil_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        cand_reg      <= cand_next;
        mag_reg       <= mag_next;
        shf_reg       <= shf_next;
        d_reg         <= d_next;
        rem_reg       <= rem_next;
        sq_reg        <= sq_next;
        cnt_reg       <= cnt_next;
        found_reg     <= found_next;
        out_value_reg <= out_value_next;
        out_found_reg <= out_found_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign prime_value = out_value_reg;
    assign found       = out_found_reg;

endmodule

[rtl/next_prime_search.sv]
// Next-prime search: for a signed value, the nearest prime away from zero.
// Input stream s_*: one transaction carries start_value in s_tdata.
// Result stream m_*: one transaction per input, prime_value in m_tdata and
// found in m_tuser (1 when prime_value is prime, 0 when the search hit its
// bound and the input came back unchanged).
// Configuration channel cfg_*: index 0 writes search_floor (16 bits, signed),
// index 1 writes search_ceiling (low 15 bits of cfg_data); other indexes are
// ignored. cfg_ready is always high. Write only while no item is in flight.
// Timing: one item is in work at a time. A candidate that is rejected goes
// through checks and stepping, as does the candidate that ends the search, plus
// a remainder pass for each odd trial divisor up to its square root; the shared
// one-bit-per-cycle remainder unit sets the length of each pass. Primes near
// 32000 take longest, most composites far less. m_tvalid rises from the output
// register after the emit step; s_tready returns after the done step.
// s_tready is high only while the sequencer waits for input.
// Reset: returns to idle, drops m_tvalid and restores floor -32000 and
// ceiling 32000. When the receiver stalls, the result holds in the output
// register and the next item may be taken but waits to emit until it drains.
module next_prime_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [nps_pkg::TDATA_WIDTH-1:0]     s_tdata,   // [15:0] start_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nps_pkg::TDATA_WIDTH-1:0]     m_tdata,   // [15:0] prime_value
    output logic                                m_tuser,   // [0] found
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [nps_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import nps_pkg::*;

    upc_t                   upc;
    ucode_t                 cw;
    status_t                status;
    logic [VALUE_WIDTH-1:0] prime_value;

    assign cfg_ready = 1'b1;

    nps_ucode_rom u_rom (
        .addr (upc),
        .cw   (cw)
    );

    nps_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cw      (cw),
        .status  (status),
        .upc     (upc)
    );

    nps_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cw          (cw),
        .status      (status),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .start_value (s_tdata[VALUE_WIDTH-1:0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .prime_value (prime_value),
        .found       (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    assign m_tdata = TDATA_WIDTH'(prime_value);

endmodule

[rtl/nps_checker.sv]
// Port-level checks for the next-prime search, bound to the top level.
// Depends on nps_pkg for the port widths.
module nps_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [nps_pkg::TDATA_WIDTH-1:0]     s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [nps_pkg::TDATA_WIDTH-1:0]     m_tdata,
    input logic                                m_tuser,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [nps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input logic [nps_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import nps_pkg::*;

    // Once an item is taken, the block works on it before taking another.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a transaction");

    // A result appears only after the block has left its input-wait step.
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the block was waiting for input");

    // A value reported prime never has magnitude zero or one.
    a_found_magnitude: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata[VALUE_WIDTH-1:0] != VALUE_WIDTH'(0)) &&
            (m_tdata[VALUE_WIDTH-1:0] != VALUE_WIDTH'(1)) &&
            (m_tdata[VALUE_WIDTH-1:0] != {VALUE_WIDTH{1'b1}}))
        else $error("found set on a magnitude below two");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind next_prime_search nps_checker u_nps_checker (.*);
